[hdl/odrm_pkg.sv]
// odrm_pkg: shared types, constants and tables for the optical depth ray march block
package odrm_pkg;

	localparam int MAX_SAMPLES = 64;

	localparam int POS_W = 36;
	localparam int DIR_W = 32;
	localparam int LEN_W = 35;
	localparam int RAD_W = 34;
	localparam int SC_W  = 7;
	localparam int OUT_W = 50;
	localparam int IDX_W = 3;
	localparam int CFG_W = 36;

	localparam logic [IDX_W-1:0] REG_CENTER_X = 3'd0;
	localparam logic [IDX_W-1:0] REG_CENTER_Y = 3'd1;
	localparam logic [IDX_W-1:0] REG_CENTER_Z = 3'd2;
	localparam logic [IDX_W-1:0] REG_RADIUS   = 3'd3;
	localparam logic [IDX_W-1:0] REG_SCALE_H  = 3'd4;
	localparam logic [IDX_W-1:0] REG_SAMPLES  = 3'd5;

	localparam logic [RAD_W-1:0] RADIUS_RST  = 34'd637100000;
	localparam logic [RAD_W-1:0] SCALE_H_RST = 34'd800000;
	localparam logic [SC_W-1:0]  SAMPLES_RST = 7'd16;

	localparam logic [31:0] LN2_Q32  = 32'd2977044472;
	localparam logic [23:0] DENS_MAX = 24'hFFFFFF;
	localparam logic [57:0] OUT_MAX  = 58'h3FFFFFFFFFFFF;

	// divider / root iteration counts, loaded as count minus one
	localparam logic [5:0] ITER_T0   = 6'd35;
	localparam logic [5:0] ITER_Q2   = 6'd35;
	localparam logic [5:0] ITER_STEP = 6'd42;
	localparam logic [5:0] ITER_ROOT = 6'd38;
	localparam logic [5:0] ITER_Z    = 6'd21;
	localparam logic [5:0] ITER_K    = 6'd4;

	localparam logic [3:0] TERM_FIRST = 4'd2;
	localparam logic [3:0] TERM_LAST  = 4'd14;

	typedef enum logic [5:0] {
		OP_IDLE,
		OP_LOAD,
		OP_DIV,
		OP_T0,
		OP_Q2,
		OP_STEP,
		OP_SBEGIN,
		OP_MUL_OFFL,
		OP_OFFL,
		OP_MUL_OFFH,
		OP_OFFH,
		OP_PADD,
		OP_MUL_SQ0,
		OP_SQ0,
		OP_MUL_SQ1,
		OP_SQ1,
		OP_MUL_SQ2,
		OP_SQ2,
		OP_SQRT,
		OP_HDIV,
		OP_Z,
		OP_KF,
		OP_MUL_TF,
		OP_TF,
		OP_MUL_TR,
		OP_TR,
		OP_TC,
		OP_DENS,
		OP_MUL_A0,
		OP_A0,
		OP_MUL_A1,
		OP_A1,
		OP_NEXT,
		OP_FIN
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [1:0] axis;
		logic [3:0] term_idx;
	} cmd_t;

	typedef struct packed {
		logic last_smp;
		logic out_free;
	} stat_t;

	// floor(2^32 / j) for the series divisors
	function automatic logic [31:0] recip(input logic [3:0] j);
		logic [31:0] r;
		unique case (j)
			4'd2:    r = 32'd2147483648;
			4'd3:    r = 32'd1431655765;
			4'd4:    r = 32'd1073741824;
			4'd5:    r = 32'd858993459;
			4'd6:    r = 32'd715827882;
			4'd7:    r = 32'd613566756;
			4'd8:    r = 32'd536870912;
			4'd9:    r = 32'd477218588;
			4'd10:   r = 32'd429496729;
			4'd11:   r = 32'd390451572;
			4'd12:   r = 32'd357913941;
			4'd13:   r = 32'd330382099;
			4'd14:   r = 32'd306783378;
			default: r = 32'hFFFFFFFF;
		endcase
		return r;
	endfunction

endpackage

[hdl/optical_depth_ray_march.sv]
// optical_depth_ray_march: top level, optical depth of a ray through an exponential atmosphere
//
// ray channel: one beat carries start point, Q2.30 direction and length; it is
// taken when ray_valid is high and ray_stall is low. ray_stall stays high while
// a ray is being marched.
// depth channel: one beat per ray carries optical_depth (Q42.8 cm, saturating);
// it is taken when depth_valid is high and depth_stall is low.
// cfg channel: cfg_ready is always high; write only while no ray is in flight.
// rays are marched one at a time: a new ray is taken only after the last one
// has finished its march.
// per sample the shared 32x32 multiplier and the one-bit-per-cycle root and
// divider do the work (39 root steps, 27 divide steps, 13 series terms).
// setup divides the length three times per ray, 115 one-bit steps in all.
// a stalled depth beat holds in the output register; the next ray is still
// taken and marched, and waits for the output register before finishing.
// reset: configuration returns to its defaults, no beat is pending.
module optical_depth_ray_march (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              ray_valid,
	output logic                              ray_stall,
	input  logic signed [odrm_pkg::POS_W-1:0] start_x,
	input  logic signed [odrm_pkg::POS_W-1:0] start_y,
	input  logic signed [odrm_pkg::POS_W-1:0] start_z,
	input  logic signed [odrm_pkg::DIR_W-1:0] dir_x,
	input  logic signed [odrm_pkg::DIR_W-1:0] dir_y,
	input  logic signed [odrm_pkg::DIR_W-1:0] dir_z,
	input  logic [odrm_pkg::LEN_W-1:0]        ray_length,
	output logic                              depth_valid,
	input  logic                              depth_stall,
	output logic [odrm_pkg::OUT_W-1:0]        optical_depth,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [odrm_pkg::IDX_W-1:0]        cfg_index,
	input  logic [odrm_pkg::CFG_W-1:0]        cfg_data
);
	import odrm_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	assign cfg_ready = 1'b1;

	odrm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.ray_valid (ray_valid),
		.ray_stall (ray_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	odrm_dpath u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.cfg_valid     (cfg_valid & cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.start_x       (start_x),
		.start_y       (start_y),
		.start_z       (start_z),
		.dir_x         (dir_x),
		.dir_y         (dir_y),
		.dir_z         (dir_z),
		.ray_length    (ray_length),
		.depth_valid   (depth_valid),
		.depth_stall   (depth_stall),
		.optical_depth (optical_depth)
	);

endmodule

[hdl/odrm_ctrl.sv]
// odrm_ctrl: sequencer that steps the datapath through setup, samples and result
module odrm_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           ray_valid,
	output logic           ray_stall,
	input  odrm_pkg::stat_t stat,
	output odrm_pkg::cmd_t  cmd
);
	import odrm_pkg::*;

	typedef enum logic {ST_IDLE, ST_RUN} state_t;

	state_t     state_q;
	op_t        op_q;
	op_t        ret_q;
	logic [5:0] cnt_q;
	logic [1:0] axis_q;
	logic [3:0] term_q;

	assign ray_stall    = (state_q != ST_IDLE);
	assign cmd.op       = op_q;
	assign cmd.axis     = axis_q;
	assign cmd.term_idx = term_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= OP_IDLE;
			ret_q   <= OP_IDLE;
			cnt_q   <= '0;
			axis_q  <= '0;
			term_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (ray_valid) begin
						state_q <= ST_RUN;
						op_q    <= OP_LOAD;
					end
				end
				ST_RUN: begin
					unique case (op_q)
						OP_LOAD: begin
							op_q  <= OP_DIV;
							cnt_q <= ITER_T0;
							ret_q <= OP_T0;
						end
						OP_DIV: begin
							if (cnt_q == '0) begin
								op_q <= ret_q;
							end else begin
								cnt_q <= cnt_q - 6'd1;
							end
						end
						OP_T0: begin
							op_q  <= OP_DIV;
							cnt_q <= ITER_Q2;
							ret_q <= OP_Q2;
						end
						OP_Q2: begin
							op_q  <= OP_DIV;
							cnt_q <= ITER_STEP;
							ret_q <= OP_STEP;
						end
						OP_STEP:     op_q <= OP_SBEGIN;
						OP_SBEGIN: begin
							axis_q <= '0;
							op_q   <= OP_MUL_OFFL;
						end
						OP_MUL_OFFL: op_q <= OP_OFFL;
						OP_OFFL:     op_q <= OP_MUL_OFFH;
						OP_MUL_OFFH: op_q <= OP_OFFH;
						OP_OFFH:     op_q <= OP_PADD;
						OP_PADD:     op_q <= OP_MUL_SQ0;
						OP_MUL_SQ0:  op_q <= OP_SQ0;
						OP_SQ0:      op_q <= OP_MUL_SQ1;
						OP_MUL_SQ1:  op_q <= OP_SQ1;
						OP_SQ1:      op_q <= OP_MUL_SQ2;
						OP_MUL_SQ2:  op_q <= OP_SQ2;
						OP_SQ2: begin
							if (axis_q == 2'd2) begin
								op_q  <= OP_SQRT;
								cnt_q <= ITER_ROOT;
							end else begin
								axis_q <= axis_q + 2'd1;
								op_q   <= OP_MUL_OFFL;
							end
						end
						OP_SQRT: begin
							if (cnt_q == '0) begin
								op_q <= OP_HDIV;
							end else begin
								cnt_q <= cnt_q - 6'd1;
							end
						end
						OP_HDIV: begin
							op_q  <= OP_DIV;
							cnt_q <= ITER_Z;
							ret_q <= OP_Z;
						end
						OP_Z: begin
							op_q  <= OP_DIV;
							cnt_q <= ITER_K;
							ret_q <= OP_KF;
						end
						OP_KF: begin
							term_q <= TERM_FIRST;
							op_q   <= OP_MUL_TF;
						end
						OP_MUL_TF:   op_q <= OP_TF;
						OP_TF:       op_q <= OP_MUL_TR;
						OP_MUL_TR:   op_q <= OP_TR;
						OP_TR:       op_q <= OP_TC;
						OP_TC: begin
							if (term_q == TERM_LAST) begin
								op_q <= OP_DENS;
							end else begin
								term_q <= term_q + 4'd1;
								op_q   <= OP_MUL_TF;
							end
						end
						OP_DENS:     op_q <= OP_MUL_A0;
						OP_MUL_A0:   op_q <= OP_A0;
						OP_A0:       op_q <= OP_MUL_A1;
						OP_MUL_A1:   op_q <= OP_A1;
						OP_A1:       op_q <= OP_NEXT;
						OP_NEXT: begin
							op_q <= stat.last_smp ? OP_FIN : OP_SBEGIN;
						end
						OP_FIN: begin
							if (stat.out_free) begin
								state_q <= ST_IDLE;
								op_q    <= OP_IDLE;
							end
						end
						default: begin
							state_q <= ST_IDLE;
							op_q    <= OP_IDLE;
						end
					endcase
				end
				default: begin
					state_q <= ST_IDLE;
					op_q    <= OP_IDLE;
				end
			endcase
		end
	end

endmodule

[hdl/odrm_dpath.sv]
// odrm_dpath: registers, shared multiplier, divider, root and series datapath
module odrm_dpath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  odrm_pkg::cmd_t                    cmd,
	output odrm_pkg::stat_t                   stat,
	input  logic                              cfg_valid,
	input  logic [odrm_pkg::IDX_W-1:0]        cfg_index,
	input  logic [odrm_pkg::CFG_W-1:0]        cfg_data,
	input  logic signed [odrm_pkg::POS_W-1:0] start_x,
	input  logic signed [odrm_pkg::POS_W-1:0] start_y,
	input  logic signed [odrm_pkg::POS_W-1:0] start_z,
	input  logic signed [odrm_pkg::DIR_W-1:0] dir_x,
	input  logic signed [odrm_pkg::DIR_W-1:0] dir_y,
	input  logic signed [odrm_pkg::DIR_W-1:0] dir_z,
	input  logic [odrm_pkg::LEN_W-1:0]        ray_length,
	output logic                              depth_valid,
	input  logic                              depth_stall,
	output logic [odrm_pkg::OUT_W-1:0]        optical_depth
);
	import odrm_pkg::*;

	// configuration
	logic signed [POS_W-1:0] cx_q, cy_q, cz_q;
	logic [RAD_W-1:0]        rad_q, hsc_q;
	logic [SC_W-1:0]         sc_q;

	// ray
	logic signed [POS_W-1:0] st_q [3];
	logic signed [DIR_W-1:0] dir_q [3];
	logic [LEN_W-1:0]        len_q;

	// divider
	logic [55:0] rem_q, dsh_q;
	logic [42:0] quo_q;

	// march position
	logic [34:0] t_q, q2_q;
	logic [7:0]  tr_q, r2_q;
	logic [42:0] step_q;
	logic [6:0]  smp_q;

	logic [63:0] prod_q;
	logic [49:0] offl_q;
	logic [36:0] off_q;
	logic [38:0] pm_q;
	logic [77:0] n_q;
	logic [38:0] root_q;
	logic [40:0] srem_q;
	logic        hneg_q;
	logic        yneg_q;
	logic signed [5:0] k_q;
	logic [31:0] f_q, term_q, x_q, qe_q;
	logic signed [34:0] sum_q;
	logic [23:0] dens_q;
	logic [57:0] acc_q;

	logic        out_v_q;
	logic [OUT_W-1:0] depth_q;

	// derived config
	logic [SC_W-1:0]  s_eff;
	logic [7:0]       s2;
	logic [RAD_W-1:0] hsc_eff;

	always_comb begin
		priority if (sc_q == '0) begin
			s_eff = 7'd1;
		end else if (sc_q > SC_W'(MAX_SAMPLES)) begin
			s_eff = SC_W'(MAX_SAMPLES);
		end else begin
			s_eff = sc_q;
		end
		s2      = {s_eff, 1'b0};
		hsc_eff = (hsc_q == '0) ? RAD_W'(1) : hsc_q;
	end

	// axis select
	logic signed [POS_W-1:0] st_sel, ce_sel;
	logic signed [DIR_W-1:0] dir_sel;
	logic [31:0]             dmag;

	always_comb begin
		unique case (cmd.axis)
			2'd0: begin
				st_sel  = st_q[0];
				dir_sel = dir_q[0];
				ce_sel  = cx_q;
			end
			2'd1: begin
				st_sel  = st_q[1];
				dir_sel = dir_q[1];
				ce_sel  = cy_q;
			end
			default: begin
				st_sel  = st_q[2];
				dir_sel = dir_q[2];
				ce_sel  = cz_q;
			end
		endcase
		dmag = dir_sel[DIR_W-1] ? (~dir_sel + 32'd1) : dir_sel;
	end

	// shared multiplier operands
	logic [31:0] mul_a, mul_b;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (cmd.op)
			OP_MUL_OFFL: begin
				mul_a = dmag;
				mul_b = 32'(t_q[17:0]);
			end
			OP_MUL_OFFH: begin
				mul_a = dmag;
				mul_b = 32'(t_q[34:18]);
			end
			OP_MUL_SQ0: begin
				mul_a = 32'(pm_q[19:0]);
				mul_b = 32'(pm_q[19:0]);
			end
			OP_MUL_SQ1: begin
				mul_a = 32'(pm_q[38:20]);
				mul_b = 32'(pm_q[19:0]);
			end
			OP_MUL_SQ2: begin
				mul_a = 32'(pm_q[38:20]);
				mul_b = 32'(pm_q[38:20]);
			end
			OP_MUL_TF: begin
				mul_a = term_q;
				mul_b = f_q;
			end
			OP_MUL_TR: begin
				mul_a = x_q;
				mul_b = recip(cmd.term_idx);
			end
			OP_MUL_A0: begin
				mul_a = 32'(dens_q);
				mul_b = 32'(step_q[42:16]);
			end
			OP_MUL_A1: begin
				mul_a = 32'(dens_q);
				mul_b = 32'(step_q[15:0]);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// combinational step values
	logic        div_ge;
	logic [67:0] off_sum;
	logic signed [39:0] off_s, p_s;
	logic [42:0] sq_cur, sq_trial;
	logic        sq_ge;
	logic signed [40:0] h_s;
	logic [39:0] hmag;
	logic [20:0] zm;
	logic [35:0] qj, rr;
	logic [31:0] qt;
	logic signed [6:0] sh_s;
	logic [5:0]  sa;
	logic [41:0] e_w, dv;
	logic [8:0]  r_sum;
	logic [40:0] rnd_lo;

	always_comb begin
		div_ge  = (rem_q >= dsh_q);
		off_sum = 68'(offl_q) + (68'(prod_q[48:0]) << 18) + (68'd1 << 29);
		off_s   = dir_sel[DIR_W-1] ? -$signed({3'b0, off_q}) : $signed({3'b0, off_q});
		p_s     = 40'(st_sel) + off_s - 40'(ce_sel);
		sq_cur   = {srem_q, n_q[77:76]};
		sq_trial = {2'b0, root_q, 2'b01};
		sq_ge    = (sq_cur >= sq_trial);
		h_s  = $signed({2'b0, root_q}) - $signed({7'b0, rad_q});
		hmag = h_s[40] ? 40'(-h_s) : h_s[39:0];
		zm   = (quo_q > 43'd1048576) ? 21'd1048576 : quo_q[20:0];
		qj   = 36'(qe_q) * 36'(cmd.term_idx);
		rr   = 36'(x_q) - qj;
		qt   = qe_q + 32'(rr >= 36'(cmd.term_idx));
		sh_s = 7'sd16 + 7'(k_q);
		e_w  = 42'(sum_q[33:0]);
		if (sh_s <= 7'sd0) begin
			sa = 6'(-sh_s);
			dv = e_w << sa;
		end else begin
			sa = 6'(sh_s);
			dv = (e_w + (42'd1 << (sa - 6'd1))) >> sa;
		end
		r_sum  = 9'(tr_q) + 9'(r2_q);
		rnd_lo = 41'(prod_q[39:0]) + 41'h8000;
	end

	assign stat.last_smp = (smp_q == (s_eff - 7'd1));
	assign stat.out_free = !out_v_q || !depth_stall;

	assign depth_valid   = out_v_q;
	assign optical_depth = depth_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q  <= '0;
			cy_q  <= '0;
			cz_q  <= '0;
			rad_q <= RADIUS_RST;
			hsc_q <= SCALE_H_RST;
			sc_q  <= SAMPLES_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_CENTER_X: cx_q  <= cfg_data;
				REG_CENTER_Y: cy_q  <= cfg_data;
				REG_CENTER_Z: cz_q  <= cfg_data;
				REG_RADIUS:   rad_q <= cfg_data[RAD_W-1:0];
				REG_SCALE_H:  hsc_q <= cfg_data[RAD_W-1:0];
				REG_SAMPLES:  sc_q  <= cfg_data[SC_W-1:0];
				default: ;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (cmd.op == OP_FIN && stat.out_free) begin
			out_v_q <= 1'b1;
		end else if (!depth_stall) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_FIN && stat.out_free) begin
			depth_q <= (acc_q > OUT_MAX) ? OUT_MAX[OUT_W-1:0] : acc_q[OUT_W-1:0];
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		unique case (cmd.op)
			OP_IDLE: begin
				st_q[0]  <= start_x;
				st_q[1]  <= start_y;
				st_q[2]  <= start_z;
				dir_q[0] <= dir_x;
				dir_q[1] <= dir_y;
				dir_q[2] <= dir_z;
				len_q    <= ray_length;
			end
			OP_LOAD: begin
				rem_q <= 56'(len_q);
				dsh_q <= 56'(s2) << 35;
				quo_q <= '0;
				acc_q <= '0;
			end
			OP_DIV: begin
				if (div_ge) begin
					rem_q <= rem_q - dsh_q;
				end
				quo_q <= {quo_q[41:0], div_ge};
				dsh_q <= dsh_q >> 1;
			end
			OP_T0: begin
				t_q   <= quo_q[34:0];
				tr_q  <= rem_q[7:0];
				rem_q <= 56'(len_q) << 1;
				dsh_q <= 56'(s2) << 35;
				quo_q <= '0;
			end
			OP_Q2: begin
				q2_q  <= quo_q[34:0];
				r2_q  <= rem_q[7:0];
				rem_q <= 56'(len_q) << 8;
				dsh_q <= 56'(s_eff) << 42;
				quo_q <= '0;
			end
			OP_STEP: begin
				step_q <= quo_q;
				smp_q  <= '0;
			end
			OP_SBEGIN: begin
				n_q    <= '0;
				root_q <= '0;
				srem_q <= '0;
			end
			OP_OFFL: offl_q <= prod_q[49:0];
			OP_OFFH: off_q  <= off_sum[66:30];
			OP_PADD: pm_q   <= p_s[39] ? 39'(-p_s) : p_s[38:0];
			OP_SQ0:  n_q    <= n_q + 78'(prod_q[39:0]);
			OP_SQ1:  n_q    <= n_q + (78'(prod_q[38:0]) << 21);
			OP_SQ2:  n_q    <= n_q + (78'(prod_q[37:0]) << 40);
			OP_SQRT: begin
				srem_q <= sq_ge ? 41'(sq_cur - sq_trial) : sq_cur[40:0];
				root_q <= {root_q[37:0], sq_ge};
				n_q    <= n_q << 2;
			end
			OP_HDIV: begin
				hneg_q <= h_s[40];
				rem_q  <= 56'(hmag) << 16;
				dsh_q  <= 56'(hsc_eff) << 21;
				quo_q  <= '0;
			end
			OP_Z: begin
				yneg_q <= hneg_q;
				rem_q  <= 56'({zm, 16'b0});
				dsh_q  <= 56'(LN2_Q32) << 4;
				quo_q  <= '0;
			end
			OP_KF: begin
				priority if (!yneg_q) begin
					k_q    <= $signed({1'b0, quo_q[4:0]});
					f_q    <= rem_q[31:0];
					term_q <= rem_q[31:0];
					sum_q  <= 35'sh100000000 - $signed(35'(rem_q[31:0]));
				end else if (rem_q[31:0] == '0) begin
					k_q    <= -$signed({1'b0, quo_q[4:0]});
					f_q    <= '0;
					term_q <= '0;
					sum_q  <= 35'sh100000000;
				end else begin
					k_q    <= -$signed({1'b0, quo_q[4:0]}) - 6'sd1;
					f_q    <= LN2_Q32 - rem_q[31:0];
					term_q <= LN2_Q32 - rem_q[31:0];
					sum_q  <= 35'sh100000000 - $signed(35'(LN2_Q32 - rem_q[31:0]));
				end
			end
			OP_TF: x_q  <= prod_q[63:32];
			OP_TR: qe_q <= prod_q[63:32];
			OP_TC: begin
				term_q <= qt;
				if (cmd.term_idx[0]) begin
					sum_q <= sum_q - $signed(35'(qt));
				end else begin
					sum_q <= sum_q + $signed(35'(qt));
				end
			end
			OP_DENS: dens_q <= (dv > 42'(DENS_MAX)) ? DENS_MAX : dv[23:0];
			OP_A0:   acc_q  <= acc_q + 58'(prod_q[50:0]);
			OP_A1:   acc_q  <= acc_q + 58'(rnd_lo[40:16]);
			OP_NEXT: begin
				smp_q <= smp_q + 7'd1;
				if (r_sum >= 9'(s2)) begin
					tr_q <= 8'(r_sum - 9'(s2));
					t_q  <= t_q + q2_q + 35'd1;
				end else begin
					tr_q <= r_sum[7:0];
					t_q  <= t_q + q2_q;
				end
			end
			default: ;
		endcase
	end

endmodule
